### rtl/obb_pkg.sv
// Shared types, widths and helper functions for the oriented box overlap pipeline.
package obb_pkg;

  localparam int POS_W   = 24;
  localparam int SIZE_W  = 23;
  localparam int TRIG_W  = 16;
  localparam int DIFF_W  = POS_W + 1;
  localparam int PROD_W  = DIFF_W + TRIG_W;
  localparam int DOT_W   = PROD_W + 1;
  localparam int DMAG_W  = DOT_W - 1;
  localparam int XPROD_W = 2 * TRIG_W;
  localparam int XDOT_W  = XPROD_W + 1;
  localparam int XMAG_W  = XDOT_W - 1;
  localparam int EXT_W   = SIZE_W + XMAG_W;
  localparam int DIST_SH = 15;
  localparam int OWN_SH  = 28;
  localparam int DIST_W  = DMAG_W + DIST_SH;
  localparam int SUM_W   = DIST_W + 1;

  typedef struct packed {
    logic signed [POS_W-1:0]  a_center_x;
    logic signed [POS_W-1:0]  a_center_y;
    logic        [SIZE_W-1:0] a_width;
    logic        [SIZE_W-1:0] a_height;
    logic signed [TRIG_W-1:0] a_cos;
    logic signed [TRIG_W-1:0] a_sin;
    logic signed [POS_W-1:0]  b_center_x;
    logic signed [POS_W-1:0]  b_center_y;
    logic        [SIZE_W-1:0] b_width;
    logic        [SIZE_W-1:0] b_height;
    logic signed [TRIG_W-1:0] b_cos;
    logic signed [TRIG_W-1:0] b_sin;
  } obb_pair_t;

  typedef struct packed {
    logic [DMAG_W-1:0] dist_a_right;
    logic [DMAG_W-1:0] dist_a_up;
    logic [DMAG_W-1:0] dist_b_right;
    logic [DMAG_W-1:0] dist_b_up;
    logic [XMAG_W-1:0] cross_c;
    logic [XMAG_W-1:0] cross_s;
    logic [SIZE_W-1:0] a_width;
    logic [SIZE_W-1:0] a_height;
    logic [SIZE_W-1:0] b_width;
    logic [SIZE_W-1:0] b_height;
  } obb_mid_t;

  function automatic logic [DMAG_W-1:0] dot_mag(input logic signed [DOT_W-1:0] v);
    logic signed [DOT_W-1:0] neg;
    neg = -v;
    return v[DOT_W-1] ? neg[DMAG_W-1:0] : v[DMAG_W-1:0];
  endfunction

  function automatic logic [XMAG_W-1:0] cross_mag(input logic signed [XDOT_W-1:0] v);
    logic signed [XDOT_W-1:0] neg;
    neg = -v;
    return v[XDOT_W-1] ? neg[XMAG_W-1:0] : v[XMAG_W-1:0];
  endfunction

endpackage

### rtl/obb_front.sv
// Front pipeline: center difference, axis products and projected magnitudes.
module obb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  obb_pkg::obb_pair_t  pair,
  output logic                out_valid,
  input  logic                out_ready,
  output obb_pkg::obb_mid_t   mid
);

  logic v1, v2, v3;
  logic en1, en2, en3;

  // stage 1
  logic signed [obb_pkg::DIFF_W-1:0] dx, dy;
  logic signed [obb_pkg::TRIG_W-1:0] ac1, as1, bc1, bs1;
  logic        [obb_pkg::SIZE_W-1:0] aw1, ah1, bw1, bh1;

  // stage 2
  logic signed [obb_pkg::PROD_W-1:0]  dx_ac, dy_as, dx_as, dy_ac;
  logic signed [obb_pkg::PROD_W-1:0]  dx_bc, dy_bs, dx_bs, dy_bc;
  logic signed [obb_pkg::XPROD_W-1:0] ac_bc, as_bs, as_bc, ac_bs;
  logic        [obb_pkg::SIZE_W-1:0]  aw2, ah2, bw2, bh2;

  // stage 3
  obb_pkg::obb_mid_t mid3;

  logic signed [obb_pkg::DOT_W-1:0]  dot_ar, dot_au, dot_br, dot_bu;
  logic signed [obb_pkg::XDOT_W-1:0] xc, xs;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v3;
  assign mid      = mid3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      dx  <= {pair.b_center_x[obb_pkg::POS_W-1], pair.b_center_x}
           - {pair.a_center_x[obb_pkg::POS_W-1], pair.a_center_x};
      dy  <= {pair.b_center_y[obb_pkg::POS_W-1], pair.b_center_y}
           - {pair.a_center_y[obb_pkg::POS_W-1], pair.a_center_y};
      ac1 <= pair.a_cos;
      as1 <= pair.a_sin;
      bc1 <= pair.b_cos;
      bs1 <= pair.b_sin;
      aw1 <= pair.a_width;
      ah1 <= pair.a_height;
      bw1 <= pair.b_width;
      bh1 <= pair.b_height;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      dx_ac <= dx * ac1;
      dy_as <= dy * as1;
      dx_as <= dx * as1;
      dy_ac <= dy * ac1;
      dx_bc <= dx * bc1;
      dy_bs <= dy * bs1;
      dx_bs <= dx * bs1;
      dy_bc <= dy * bc1;
      ac_bc <= ac1 * bc1;
      as_bs <= as1 * bs1;
      as_bc <= as1 * bc1;
      ac_bs <= ac1 * bs1;
      aw2   <= aw1;
      ah2   <= ah1;
      bw2   <= bw1;
      bh2   <= bh1;
    end
  end

  always_comb begin
    dot_ar = obb_pkg::DOT_W'(dx_ac) + obb_pkg::DOT_W'(dy_as);
    dot_au = obb_pkg::DOT_W'(dy_ac) - obb_pkg::DOT_W'(dx_as);
    dot_br = obb_pkg::DOT_W'(dx_bc) + obb_pkg::DOT_W'(dy_bs);
    dot_bu = obb_pkg::DOT_W'(dy_bc) - obb_pkg::DOT_W'(dx_bs);
    xc     = obb_pkg::XDOT_W'(ac_bc) + obb_pkg::XDOT_W'(as_bs);
    xs     = obb_pkg::XDOT_W'(as_bc) - obb_pkg::XDOT_W'(ac_bs);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      mid3.dist_a_right <= obb_pkg::dot_mag(dot_ar);
      mid3.dist_a_up    <= obb_pkg::dot_mag(dot_au);
      mid3.dist_b_right <= obb_pkg::dot_mag(dot_br);
      mid3.dist_b_up    <= obb_pkg::dot_mag(dot_bu);
      mid3.cross_c      <= obb_pkg::cross_mag(xc);
      mid3.cross_s      <= obb_pkg::cross_mag(xs);
      mid3.a_width      <= aw2;
      mid3.a_height     <= ah2;
      mid3.b_width      <= bw2;
      mid3.b_height     <= bh2;
    end
  end

endmodule

### rtl/obb_back.sv
// Back pipeline: projected extents of the other box and the per-axis separation compare.
module obb_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  obb_pkg::obb_mid_t  mid,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               overlap
);

  logic v4, v5;
  logic en4, en5;

  logic [obb_pkg::EXT_W-1:0]  bh_s, bw_c, bh_c, bw_s;
  logic [obb_pkg::EXT_W-1:0]  ah_s, aw_c, ah_c, aw_s;
  logic [obb_pkg::DMAG_W-1:0] d_ar, d_au, d_br, d_bu;
  logic [obb_pkg::SIZE_W-1:0] aw4, ah4, bw4, bh4;

  logic [obb_pkg::SUM_W-1:0] lim_ar, lim_au, lim_br, lim_bu;
  logic                      sep;

  assign en5       = !v5 || out_ready;
  assign en4       = !v4 || en5;
  assign in_ready  = en4;
  assign out_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en4) v4 <= in_valid;
      if (en5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      bh_s <= obb_pkg::EXT_W'(mid.b_height) * obb_pkg::EXT_W'(mid.cross_s);
      bw_c <= obb_pkg::EXT_W'(mid.b_width)  * obb_pkg::EXT_W'(mid.cross_c);
      bh_c <= obb_pkg::EXT_W'(mid.b_height) * obb_pkg::EXT_W'(mid.cross_c);
      bw_s <= obb_pkg::EXT_W'(mid.b_width)  * obb_pkg::EXT_W'(mid.cross_s);
      ah_s <= obb_pkg::EXT_W'(mid.a_height) * obb_pkg::EXT_W'(mid.cross_s);
      aw_c <= obb_pkg::EXT_W'(mid.a_width)  * obb_pkg::EXT_W'(mid.cross_c);
      ah_c <= obb_pkg::EXT_W'(mid.a_height) * obb_pkg::EXT_W'(mid.cross_c);
      aw_s <= obb_pkg::EXT_W'(mid.a_width)  * obb_pkg::EXT_W'(mid.cross_s);
      d_ar <= mid.dist_a_right;
      d_au <= mid.dist_a_up;
      d_br <= mid.dist_b_right;
      d_bu <= mid.dist_b_up;
      aw4  <= mid.a_width;
      ah4  <= mid.a_height;
      bw4  <= mid.b_width;
      bh4  <= mid.b_height;
    end
  end

  always_comb begin
    lim_ar = obb_pkg::SUM_W'(bh_s) + obb_pkg::SUM_W'(bw_c)
           + obb_pkg::SUM_W'({aw4, obb_pkg::OWN_SH'(0)});
    lim_au = obb_pkg::SUM_W'(bh_c) + obb_pkg::SUM_W'(bw_s)
           + obb_pkg::SUM_W'({ah4, obb_pkg::OWN_SH'(0)});
    lim_br = obb_pkg::SUM_W'(ah_s) + obb_pkg::SUM_W'(aw_c)
           + obb_pkg::SUM_W'({bw4, obb_pkg::OWN_SH'(0)});
    lim_bu = obb_pkg::SUM_W'(ah_c) + obb_pkg::SUM_W'(aw_s)
           + obb_pkg::SUM_W'({bh4, obb_pkg::OWN_SH'(0)});
    sep = (obb_pkg::SUM_W'({d_ar, obb_pkg::DIST_SH'(0)}) > lim_ar)
       || (obb_pkg::SUM_W'({d_au, obb_pkg::DIST_SH'(0)}) > lim_au)
       || (obb_pkg::SUM_W'({d_br, obb_pkg::DIST_SH'(0)}) > lim_br)
       || (obb_pkg::SUM_W'({d_bu, obb_pkg::DIST_SH'(0)}) > lim_bu);
  end

  always_ff @(posedge clk) begin
    if (en5) overlap <= !sep;
  end

endmodule

### rtl/oriented_box_overlap_test.sv
// Top level of the 2D oriented box overlap test.
// Runs the separating axis test on the four axes of two oriented boxes and reports
// overlap (touching counts as overlap), exactly, with no rounding. A pair enters every
// cycle while in_ready is high; each result then passes in order through
// five register stages (center difference, axis products, projected magnitudes, extent
// products, compare). A result that is not taken holds only the stages behind it that
// carry requests; empty stages keep filling, and in_ready drops once all five are full.
module oriented_box_overlap_test (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [obb_pkg::POS_W-1:0]      box_a_center_x,
  input  logic signed [obb_pkg::POS_W-1:0]      box_a_center_y,
  input  logic        [obb_pkg::SIZE_W-1:0]     box_a_width,
  input  logic        [obb_pkg::SIZE_W-1:0]     box_a_height,
  input  logic signed [obb_pkg::TRIG_W-1:0]     box_a_cos,
  input  logic signed [obb_pkg::TRIG_W-1:0]     box_a_sin,
  input  logic signed [obb_pkg::POS_W-1:0]      box_b_center_x,
  input  logic signed [obb_pkg::POS_W-1:0]      box_b_center_y,
  input  logic        [obb_pkg::SIZE_W-1:0]     box_b_width,
  input  logic        [obb_pkg::SIZE_W-1:0]     box_b_height,
  input  logic signed [obb_pkg::TRIG_W-1:0]     box_b_cos,
  input  logic signed [obb_pkg::TRIG_W-1:0]     box_b_sin,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  overlap
);

  obb_pkg::obb_pair_t pair;
  obb_pkg::obb_mid_t  mid;
  logic               mid_valid, mid_ready;

  always_comb begin
    pair.a_center_x = box_a_center_x;
    pair.a_center_y = box_a_center_y;
    pair.a_width    = box_a_width;
    pair.a_height   = box_a_height;
    pair.a_cos      = box_a_cos;
    pair.a_sin      = box_a_sin;
    pair.b_center_x = box_b_center_x;
    pair.b_center_y = box_b_center_y;
    pair.b_width    = box_b_width;
    pair.b_height   = box_b_height;
    pair.b_cos      = box_b_cos;
    pair.b_sin      = box_b_sin;
  end

  obb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pair      (pair),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .mid       (mid)
  );

  obb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .mid       (mid),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .overlap   (overlap)
  );

endmodule

### rtl/obb_checker.sv
// Port-level checks for the oriented box overlap test, bound to the top level.
module obb_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic overlap
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(overlap))
    else $error("stalled result dropped or changed");

  a_flow_through: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("request refused while results drain");

  a_empty_out_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request refused with output stage empty");

endmodule

bind oriented_box_overlap_test obb_checker u_obb_checker (.*);
